[rtl/smc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types, register codes and a saturation helper for the sliding mode
// control step unit.
// ----------------------------------------------------------------------------
package smc_pkg;

  localparam int DATA_W        = 32;
  localparam int COEF_W        = 31;
  localparam int PROD_W        = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic signed [PROD_W-1:0] WIDE_MAX = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] WIDE_MIN = -64'sd2147483648;
  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh80000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAMBDA,
    REG_LINEAR_GAIN,
    REG_SWITCH_GAIN,
    REG_BOUNDARY_INV,
    REG_GAIN_INV,
    REG_OUTPUT_LIMIT
  } cfg_reg_t;

  typedef struct packed {
    logic        [COEF_W-1:0] lambda;
    logic        [COEF_W-1:0] linear_gain;
    logic        [COEF_W-1:0] switch_gain;
    logic        [COEF_W-1:0] boundary_inverse;
    logic signed [DATA_W-1:0] gain_recip;
    logic        [COEF_W-1:0] output_limit;
  } smc_cfg_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] surface;
    logic signed [DATA_W-1:0] lambda_rate;
    logic signed [DATA_W:0]   accel_diff;
  } smc_surf_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] sum;
    logic signed [DATA_W-1:0] surface;
  } smc_sum_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > WIDE_MAX) begin
      sat32 = DATA_MAX;
    end else if (v < WIDE_MIN) begin
      sat32 = DATA_MIN;
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage

[rtl/sliding_mode_control_step_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_mode_control_step_unit
// Sliding mode controller with boundary layer, one control sample per
// transaction, fully pipelined fixed point datapath.
// ----------------------------------------------------------------------------
// A new sample is taken on every clock with start high; busy stays low, so
// the unit accepts one transaction per cycle without pause. Each sample
// passes nine register stages (errors, lambda products, surface, boundary
// and linear products, switching clamp, switching product, term sum, gain
// product, limit) and its drive and surface appear with done for a single
// cycle, out of the limit stage. The chain of four dependent multiplications
// sets the depth of the pipeline. The receiver cannot stall the unit, so
// it must take every result in the cycle done is high. Coefficients are
// written through cfg_we/cfg_index/cfg_data and should only change while no
// sample is in flight.
// ----------------------------------------------------------------------------
module sliding_mode_control_step_unit
  import smc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] target_value,
  input  logic signed [DATA_W-1:0] target_rate,
  input  logic signed [DATA_W-1:0] target_accel,
  input  logic signed [DATA_W-1:0] measured_value,
  input  logic signed [DATA_W-1:0] measured_rate,
  input  logic signed [DATA_W-1:0] model_term,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  output logic                     done,
  output logic signed [DATA_W-1:0] drive,
  output logic signed [DATA_W-1:0] surface
);

  smc_cfg_t  cfg;
  smc_surf_t surf_stage;
  smc_sum_t  sum_stage;
  logic      accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  smc_config #(.FRAC_BITS(FRAC_BITS)) u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  smc_surface #(.FRAC_BITS(FRAC_BITS)) u_surface (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (accept),
    .target_value   (target_value),
    .target_rate    (target_rate),
    .target_accel   (target_accel),
    .measured_value (measured_value),
    .measured_rate  (measured_rate),
    .model_term     (model_term),
    .cfg            (cfg),
    .out            (surf_stage)
  );

  smc_reach #(.FRAC_BITS(FRAC_BITS)) u_reach (
    .clk (clk),
    .rst (rst),
    .in  (surf_stage),
    .cfg (cfg),
    .out (sum_stage)
  );

  smc_drive #(.FRAC_BITS(FRAC_BITS)) u_drive (
    .clk     (clk),
    .rst     (rst),
    .in      (sum_stage),
    .cfg     (cfg),
    .done    (done),
    .drive   (drive),
    .surface (surface)
  );

endmodule

[rtl/smc_config.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_config
// Coefficient register file written through the plain configuration port.
// ----------------------------------------------------------------------------
module smc_config
  import smc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output smc_cfg_t             cfg
);

  localparam logic [COEF_W-1:0] ONE_COEF = COEF_W'(64'd1 << FRAC_BITS);
  localparam logic [DATA_W-1:0] ONE_DATA = DATA_W'(64'd1 << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lambda           <= ONE_COEF;
      cfg.linear_gain      <= '0;
      cfg.switch_gain      <= ONE_COEF;
      cfg.boundary_inverse <= ONE_COEF;
      cfg.gain_recip       <= ONE_DATA;
      cfg.output_limit     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LAMBDA:       cfg.lambda           <= cfg_data[COEF_W-1:0];
        REG_LINEAR_GAIN:  cfg.linear_gain      <= cfg_data[COEF_W-1:0];
        REG_SWITCH_GAIN:  cfg.switch_gain      <= cfg_data[COEF_W-1:0];
        REG_BOUNDARY_INV: cfg.boundary_inverse <= cfg_data[COEF_W-1:0];
        REG_GAIN_INV:     cfg.gain_recip       <= cfg_data;
        REG_OUTPUT_LIMIT: cfg.output_limit     <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/smc_surface.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_surface
// Three stages: tracking errors, lambda products, saturated sliding surface.
// ----------------------------------------------------------------------------
module smc_surface
  import smc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [DATA_W-1:0] target_value,
  input  logic signed [DATA_W-1:0] target_rate,
  input  logic signed [DATA_W-1:0] target_accel,
  input  logic signed [DATA_W-1:0] measured_value,
  input  logic signed [DATA_W-1:0] measured_rate,
  input  logic signed [DATA_W-1:0] model_term,
  input  smc_cfg_t                 cfg,
  output smc_surf_t                out
);

  // stage 1
  logic                     v1;
  logic signed [DATA_W-1:0] err1;
  logic signed [DATA_W-1:0] derr1;
  logic signed [DATA_W:0]   adiff1;
  // stage 2
  logic                     v2;
  logic signed [PROD_W-1:0] prod_le2;
  logic signed [PROD_W-1:0] prod_lde2;
  logic signed [DATA_W-1:0] derr2;
  logic signed [DATA_W:0]   adiff2;

  logic signed [PROD_W-1:0] err_wide;
  logic signed [PROD_W-1:0] derr_wide;
  logic signed [DATA_W-1:0] le_term;
  logic signed [PROD_W-1:0] surf_wide;
  logic signed [DATA_W-1:0] lambda_s;

  assign err_wide  = PROD_W'(target_value) - PROD_W'(measured_value);
  assign derr_wide = PROD_W'(target_rate) - PROD_W'(measured_rate);
  assign lambda_s  = $signed({1'b0, cfg.lambda});
  assign le_term   = sat32(prod_le2 >>> FRAC_BITS);
  assign surf_wide = PROD_W'(derr2) + PROD_W'(le_term);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out.valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out.valid <= v2;
    end
    err1            <= sat32(err_wide);
    derr1           <= sat32(derr_wide);
    adiff1          <= (DATA_W+1)'(target_accel) - (DATA_W+1)'(model_term);
    prod_le2        <= PROD_W'(lambda_s) * PROD_W'(err1);
    prod_lde2       <= PROD_W'(lambda_s) * PROD_W'(derr1);
    derr2           <= derr1;
    adiff2          <= adiff1;
    out.surface     <= sat32(surf_wide);
    out.lambda_rate <= sat32(prod_lde2 >>> FRAC_BITS);
    out.accel_diff  <= adiff2;
  end

  a_surf_latency: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> $past(in_valid, 3))
    else $error("surface stage valid without an input three cycles earlier");

endmodule

[rtl/smc_reach.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_reach
// Four stages: boundary and linear products, switching clamp, switching
// product, saturated sum of the reaching law terms.
// ----------------------------------------------------------------------------
module smc_reach
  import smc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  smc_surf_t in,
  input  smc_cfg_t  cfg,
  output smc_sum_t  out
);

  localparam logic signed [PROD_W-1:0] ONE_WIDE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [DATA_W-1:0] ONE_DATA = DATA_W'(ONE_WIDE);

  // stage 4
  logic                     v4;
  logic signed [PROD_W-1:0] prod_bnd4;
  logic signed [PROD_W-1:0] prod_lin4;
  smc_surf_t                hold4;
  // stage 5
  logic                     v5;
  logic signed [DATA_W-1:0] sw5;
  logic signed [DATA_W-1:0] lin5;
  smc_surf_t                hold5;
  // stage 6
  logic                     v6;
  logic signed [PROD_W-1:0] prod_sw6;
  logic signed [DATA_W-1:0] lin6;
  smc_surf_t                hold6;

  logic signed [PROD_W-1:0] bnd_shift;
  logic signed [DATA_W-1:0] sw_next;
  logic signed [PROD_W-1:0] sum_wide;

  assign bnd_shift = prod_bnd4 >>> FRAC_BITS;

  always_comb begin
    priority if (bnd_shift > ONE_WIDE) begin
      sw_next = ONE_DATA;
    end else if (bnd_shift < -ONE_WIDE) begin
      sw_next = -ONE_DATA;
    end else begin
      sw_next = bnd_shift[DATA_W-1:0];
    end
  end

  assign sum_wide = PROD_W'(hold6.accel_diff) + PROD_W'(hold6.lambda_rate)
                  + PROD_W'(lin6) + PROD_W'(sat32(prod_sw6 >>> FRAC_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out.valid <= 1'b0;
    end else begin
      v4        <= in.valid;
      v5        <= v4;
      v6        <= v5;
      out.valid <= v6;
    end
    prod_bnd4   <= PROD_W'(in.surface)
                 * PROD_W'($signed({1'b0, cfg.boundary_inverse}));
    prod_lin4   <= PROD_W'(in.surface) * PROD_W'($signed({1'b0, cfg.linear_gain}));
    hold4       <= in;
    sw5         <= sw_next;
    lin5        <= sat32(prod_lin4 >>> FRAC_BITS);
    hold5       <= hold4;
    prod_sw6    <= PROD_W'(sw5) * PROD_W'($signed({1'b0, cfg.switch_gain}));
    lin6        <= lin5;
    hold6       <= hold5;
    out.sum     <= sat32(sum_wide);
    out.surface <= hold6.surface;
  end

  a_switch_bound: assert property (@(posedge clk) disable iff (rst)
    v5 |-> (sw5 <= ONE_DATA && sw5 >= -ONE_DATA))
    else $error("switching term outside the boundary layer range");

endmodule

[rtl/smc_drive.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_drive
// Two stages: gain product, then saturation, drive limit and output register.
// ----------------------------------------------------------------------------
module smc_drive
  import smc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  smc_sum_t                 in,
  input  smc_cfg_t                 cfg,
  output logic                     done,
  output logic signed [DATA_W-1:0] drive,
  output logic signed [DATA_W-1:0] surface
);

  logic                     v8;
  logic signed [PROD_W-1:0] prod8;
  logic signed [DATA_W-1:0] surf8;

  logic signed [DATA_W-1:0] drive_sat;
  logic signed [DATA_W-1:0] drive_next;
  logic signed [DATA_W-1:0] limit_s;

  assign drive_sat = sat32(prod8 >>> FRAC_BITS);
  assign limit_s   = $signed({1'b0, cfg.output_limit});

  always_comb begin
    priority if (limit_s == '0) begin
      drive_next = drive_sat;
    end else if (drive_sat > limit_s) begin
      drive_next = limit_s;
    end else if (drive_sat < -limit_s) begin
      drive_next = -limit_s;
    end else begin
      drive_next = drive_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8   <= 1'b0;
      done <= 1'b0;
    end else begin
      v8   <= in.valid;
      done <= v8;
    end
  end

  always_ff @(posedge clk) begin
    prod8   <= PROD_W'(in.sum) * PROD_W'(cfg.gain_recip);
    surf8   <= in.surface;
    drive   <= drive_next;
    surface <= surf8;
  end

  a_drive_limit: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(limit_s) == '0
              || (drive <= $past(limit_s) && drive >= -$past(limit_s))))
    else $error("drive outside the configured limit");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding mode control step unit. Samples are
// sent through the start/busy handshake with random idle bursts. A scoreboard
// computes the expected drive and surface of every accepted transaction. It
// checks each done strobe against the oldest expectation. Coefficient
// registers are rewritten between phases, once the pipeline is empty.
// ----------------------------------------------------------------------------
import smc_pkg::*;

class smc_scoreboard;
  localparam int FRAC = FRAC_BITS_DEF;

  logic        [COEF_W-1:0] lambda_r;
  logic        [COEF_W-1:0] linear_gain_r;
  logic        [COEF_W-1:0] switch_gain_r;
  logic        [COEF_W-1:0] boundary_inv_r;
  logic signed [DATA_W-1:0] gain_inv_r;
  logic        [COEF_W-1:0] output_limit_r;

  logic signed [DATA_W-1:0] exp_drive[$];
  logic signed [DATA_W-1:0] exp_surface[$];
  int errors;

  function new();
    lambda_r       = COEF_W'(1) << FRAC;
    linear_gain_r  = '0;
    switch_gain_r  = COEF_W'(1) << FRAC;
    boundary_inv_r = COEF_W'(1) << FRAC;
    gain_inv_r     = DATA_W'(1) << FRAC;
    output_limit_r = '0;
    errors         = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    case (idx)
      REG_LAMBDA:       lambda_r       = data[COEF_W-1:0];
      REG_LINEAR_GAIN:  linear_gain_r  = data[COEF_W-1:0];
      REG_SWITCH_GAIN:  switch_gain_r  = data[COEF_W-1:0];
      REG_BOUNDARY_INV: boundary_inv_r = data[COEF_W-1:0];
      REG_GAIN_INV:     gain_inv_r     = data;
      REG_OUTPUT_LIMIT: output_limit_r = data[COEF_W-1:0];
      default: ;
    endcase
  endfunction

  function longint clip32(longint v);
    if (v > longint'(DATA_MAX)) return longint'(DATA_MAX);
    if (v < longint'(DATA_MIN)) return longint'(DATA_MIN);
    return v;
  endfunction

  // exact product, floored by the fraction width
  function longint mulfix(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  function void note_sample(logic signed [DATA_W-1:0] tv, logic signed [DATA_W-1:0] tr,
                            logic signed [DATA_W-1:0] ta, logic signed [DATA_W-1:0] mv,
                            logic signed [DATA_W-1:0] mr, logic signed [DATA_W-1:0] md);
    longint one;
    longint err;
    longint err_rate;
    longint surf;
    longint sw;
    longint acc;
    longint drv;
    longint lim;
    one      = longint'(1) << FRAC;
    err      = clip32(longint'(tv) - longint'(mv));
    err_rate = clip32(longint'(tr) - longint'(mr));
    surf     = clip32(err_rate + clip32(mulfix(longint'(lambda_r), err)));
    sw = mulfix(surf, longint'(boundary_inv_r));
    if (sw > one) sw = one;
    if (sw < -one) sw = -one;
    acc = longint'(ta) - longint'(md)
        + clip32(mulfix(longint'(lambda_r), err_rate))
        + clip32(mulfix(longint'(linear_gain_r), surf))
        + clip32(mulfix(longint'(switch_gain_r), sw));
    acc = clip32(acc);
    drv = clip32(mulfix(acc, longint'(gain_inv_r)));
    if (output_limit_r != '0) begin
      lim = longint'(output_limit_r);
      if (drv > lim) drv = lim;
      if (drv < -lim) drv = -lim;
    end
    exp_drive.push_back(drv[DATA_W-1:0]);
    exp_surface.push_back(surf[DATA_W-1:0]);
  endfunction

  function void check_result(logic signed [DATA_W-1:0] drv, logic signed [DATA_W-1:0] surf);
    logic signed [DATA_W-1:0] want_drive;
    logic signed [DATA_W-1:0] want_surface;
    if (exp_drive.size() == 0) begin
      $error("unexpected result: drive %0d surface %0d", drv, surf);
      errors++;
      return;
    end
    want_drive   = exp_drive.pop_front();
    want_surface = exp_surface.pop_front();
    if (drv !== want_drive) begin
      $error("drive mismatch: expected %0d actual %0d", want_drive, drv);
      errors++;
    end
    if (surf !== want_surface) begin
      $error("surface mismatch: expected %0d actual %0d", want_surface, surf);
      errors++;
    end
  endfunction

  function int pending();
    return exp_drive.size();
  endfunction
endclass

module tb;
  localparam int STALL_LIMIT = 5000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] tv;
    logic signed [DATA_W-1:0] tr;
    logic signed [DATA_W-1:0] ta;
    logic signed [DATA_W-1:0] mv;
    logic signed [DATA_W-1:0] mr;
    logic signed [DATA_W-1:0] md;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [DATA_W-1:0] target_value = '0;
  logic signed [DATA_W-1:0] target_rate = '0;
  logic signed [DATA_W-1:0] target_accel = '0;
  logic signed [DATA_W-1:0] measured_value = '0;
  logic signed [DATA_W-1:0] measured_rate = '0;
  logic signed [DATA_W-1:0] model_term = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic done;
  logic signed [DATA_W-1:0] drive;
  logic signed [DATA_W-1:0] surface;

  smc_scoreboard sb;
  int stall_count = 0;

  always #4 clk = ~clk;

  sliding_mode_control_step_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .target_value(target_value), .target_rate(target_rate),
    .target_accel(target_accel), .measured_value(measured_value),
    .measured_rate(measured_rate), .model_term(model_term),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .drive(drive), .surface(surface)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (done) sb.check_result(drive, surface);
      if (start && !busy) begin
        sb.note_sample(target_value, target_rate, target_accel,
                       measured_value, measured_rate, model_term);
      end
      if ((start && !busy) || done || cfg_we) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
      if (stall_count >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_sample(sample_t smp);
    start          <= 1'b1;
    target_value   <= smp.tv;
    target_rate    <= smp.tr;
    target_accel   <= smp.ta;
    measured_value <= smp.mv;
    measured_rate  <= smp.mr;
    model_term     <= smp.md;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_for(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drain the pipeline before touching the coefficients
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic sample_t mk(logic signed [DATA_W-1:0] tv, logic signed [DATA_W-1:0] tr,
                                 logic signed [DATA_W-1:0] ta, logic signed [DATA_W-1:0] mv,
                                 logic signed [DATA_W-1:0] mr, logic signed [DATA_W-1:0] md);
    sample_t s;
    s = '{tv, tr, ta, mv, mr, md};
    return s;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_field();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      3:       v = $urandom_range(0, 512) - 256;
      4, 5, 6: v = $urandom;
      7:       v = DATA_MAX;
      8:       v = DATA_MIN;
      default: v = '0;
    endcase
    return v;
  endfunction

  // mostly samples near the target so the boundary layer is exercised
  function automatic sample_t rand_sample();
    sample_t s;
    s.tv = rand_field();
    s.tr = rand_field();
    s.ta = rand_field();
    s.md = rand_field();
    if ($urandom_range(0, 9) < 6) begin
      s.mv = s.tv + ($urandom_range(0, 32'h0000_4000) - 32'h0000_2000);
      s.mr = s.tr + ($urandom_range(0, 32'h0000_4000) - 32'h0000_2000);
    end else begin
      s.mv = rand_field();
      s.mr = rand_field();
    end
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] rand_coef();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 8))
      0:       v = '0;
      1:       v = 32'd1;
      2:       v = 32'h7fff_ffff;
      3:       v = 32'hffff_ffff;
      4, 5:    v = $urandom_range(0, 32'h0004_0000);
      6:       v = $urandom_range(0, 32'h0000_4000) | 32'h8000_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] rand_gain_inv();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 8))
      0, 1:    v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2:       v = DATA_MIN;
      3:       v = DATA_MAX;
      4:       v = '0;
      5:       v = Q_ONE;
      6:       v = -Q_ONE;
      7:       v = $urandom_range(0, 32'h0000_8000);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic random_config();
    write_cfg(REG_LAMBDA, rand_coef());
    write_cfg(REG_LINEAR_GAIN, rand_coef());
    write_cfg(REG_SWITCH_GAIN, rand_coef());
    write_cfg(REG_BOUNDARY_INV, rand_coef());
    write_cfg(REG_GAIN_INV, rand_gain_inv());
    write_cfg(REG_OUTPUT_LIMIT, ($urandom_range(0, 1) == 0) ? '0 : rand_coef());
    if ($urandom_range(0, 3) == 0) begin
      write_cfg(($urandom_range(0, 1) == 0) ? REG_UNUSED_LO : REG_UNUSED_HI, $urandom);
    end
  endtask

  task automatic random_phase(int n_items, int idle_pct);
    for (int i = 0; i < n_items; i++) begin
      send_sample(rand_sample());
      if ($urandom_range(0, 99) < idle_pct) idle_for($urandom_range(1, 15));
    end
  endtask

  initial begin
    int idle_pct;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficients, field extremes and saturation corners
    send_sample(mk('0, '0, '0, '0, '0, '0));
    send_sample(mk(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX));
    send_sample(mk(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN));
    send_sample(mk(DATA_MAX, DATA_MAX, '0, DATA_MIN, DATA_MIN, '0));
    send_sample(mk(DATA_MIN, DATA_MIN, '0, DATA_MAX, DATA_MAX, '0));
    send_sample(mk(DATA_MAX, '0, DATA_MAX, '0, '0, DATA_MIN));
    send_sample(mk(DATA_MIN, '0, DATA_MIN, '0, '0, DATA_MAX));
    idle_for(3);
    send_sample(mk(32'sh0001_8000, 32'sh0000_4000, Q_ONE, 32'sh0001_7000, '0, -Q_ONE));
    send_sample(mk(-32'sd5, 32'sd3, -32'sd1, 32'sd2, -32'sd7, 32'sd1));
    send_sample(mk(32'sh0002_0000, -32'sh0001_0000, '0, '0, 32'sh0000_0001, '0));
    drain();

    // zero coefficients are used as written
    write_cfg(REG_LAMBDA, '0);
    write_cfg(REG_SWITCH_GAIN, '0);
    write_cfg(REG_BOUNDARY_INV, '0);
    write_cfg(REG_GAIN_INV, '0);
    send_sample(mk(32'sh0003_0000, Q_ONE, Q_ONE, '0, '0, '0));
    send_sample(mk(DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN));
    drain();

    // largest coefficients, bit 31 of the 31-bit registers dropped, limit on
    write_cfg(REG_LAMBDA, 32'hffff_ffff);
    write_cfg(REG_LINEAR_GAIN, 32'hffff_ffff);
    write_cfg(REG_SWITCH_GAIN, 32'h7fff_ffff);
    write_cfg(REG_BOUNDARY_INV, 32'hffff_ffff);
    write_cfg(REG_GAIN_INV, DATA_MIN);
    write_cfg(REG_OUTPUT_LIMIT, 32'h8001_0000);
    send_sample(mk(32'sh0000_0010, '0, '0, '0, '0, '0));
    send_sample(mk(-32'sh0000_0010, '0, '0, '0, '0, '0));
    send_sample(mk(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MIN, DATA_MIN, DATA_MIN));
    drain();

    // writes to unused indices leave everything alone
    write_cfg(REG_LINEAR_GAIN, 32'h0000_8000);
    write_cfg(REG_GAIN_INV, DATA_MAX);
    write_cfg(REG_OUTPUT_LIMIT, 32'h7fff_ffff);
    write_cfg(REG_UNUSED_LO, 32'hffff_ffff);
    write_cfg(REG_UNUSED_HI, '0);
    send_sample(mk(Q_ONE, -Q_ONE, 32'sh0000_1000, 32'sh0000_8000, Q_ONE, '0));
    send_sample(mk(DATA_MIN, '0, DATA_MIN, '0, '0, DATA_MAX));
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      random_config();
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 5;
        2:       idle_pct = 20;
        default: idle_pct = 50;
      endcase
      if (ph == 9) idle_pct = 0;
      random_phase(140, idle_pct);
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
